/* rtl/ppfs_pkg.sv */
// shared types, codes and color expansion helpers for the palette pixel frame streamer
// no dependencies; imported by every module of the block
`default_nettype none

package ppfs_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int NUM_RES = 3;
  localparam int CNT_W = 2;

  typedef enum logic [2:0] {
    ACT_PAL   = 3'd0,
    ACT_START = 3'd1,
    ACT_PIXEL = 3'd2,
    ACT_END   = 3'd3,
    ACT_INIT  = 3'd4
  } action_t;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_DWORD   = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd2;
  localparam logic [2:0] REG_NEW_SIG      = 3'd3;
  localparam logic [2:0] REG_ABORT_SIG    = 3'd4;
  localparam logic [2:0] REG_INIT_SIG     = 3'd5;

  localparam logic [1:0] FMT_PAL8   = 2'd0;
  localparam logic [1:0] FMT_RGB555 = 2'd1;
  localparam logic [1:0] FMT_RGB565 = 2'd2;
  localparam logic [1:0] FMT_RGB32  = 2'd3;

  localparam logic [7:0] END_OK_BYTE = 8'h01;

  // work decided at accept time, carried to the result builder
  typedef enum logic [2:0] {
    OP_REFUSED,
    OP_START,
    OP_PIXEL,
    OP_END_ABORT,
    OP_END_OK,
    OP_INIT
  } op_t;

  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [1:0]  pixel_format;
    logic [31:0] new_sig;
    logic [31:0] abort_sig;
    logic [31:0] init_sig;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] data;
    logic        last;
  } result_t;

  // 5-bit channel to 8 bits: (x * 0x21) >> 2
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [9:0] p;
    p = 10'(x) * 10'h21;
    return p[9:2];
  endfunction

  // 6-bit channel to 8 bits: (x * 0x41) >> 4
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [11:0] p;
    p = 12'(x) * 12'h41;
    return p[11:4];
  endfunction

endpackage

`default_nettype wire

/* rtl/palette_pixel_frame_streamer.sv */
// top level of the palette pixel frame streamer: request decode, frame state, config
// uses ppfs_pkg, ppfs_palette, ppfs_result_build and ppfs_emitter
`default_nettype none

// Requests enter on in_valid/in_ready, one per cycle when the output side keeps
// up. The output sends one result per cycle while out_ready is high, so a pixel
// gives 3 results, a frame start 2, frame end, initialise and refused start 1,
// and a palette write or a pixel of a skipped frame none. Throughput is set by the
// single result port; the palette color is read from a synchronous memory at
// accept and used from the registered request stage, with the next request
// accepted meanwhile. Palette entries are cleared at reset by per-entry valid
// bits, so no clearing pass is needed. Configuration registers are written on
// cfg_valid/cfg_ready (always ready) and must only change while the block idles.
module palette_pixel_frame_streamer #(
  parameter int PALETTE_DEPTH = ppfs_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  pal_index,
  input  wire logic [7:0]  pal_red,
  input  wire logic [7:0]  pal_green,
  input  wire logic [7:0]  pal_blue,
  input  wire logic [31:0] pixel_value,
  input  wire logic        discard,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      data,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import ppfs_pkg::*;

  cfg_t cfg;
  logic init_done;
  logic [1:0] skip_count;
  logic draw_enable;

  logic s1_valid;
  op_t s1_op;
  logic [31:0] s1_pix;

  logic accept;
  logic advance;
  logic load_ok;
  logic has_res;
  op_t op_next;
  logic pal_wr;
  logic pal_rd;
  logic [23:0] pal_rgb;

  result_t [NUM_RES-1:0] res;
  logic [CNT_W-1:0] cnt;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign advance = s1_valid && load_ok;
  assign in_ready = !s1_valid || load_ok;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width <= cfg_data[15:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[15:0];
        REG_PIXEL_FORMAT: cfg.pixel_format <= cfg_data[1:0];
        REG_NEW_SIG:      cfg.new_sig <= cfg_data;
        REG_ABORT_SIG:    cfg.abort_sig <= cfg_data;
        REG_INIT_SIG:     cfg.init_sig <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // decode the request against the current frame state
  always_comb begin
    has_res = 1'b0;
    op_next = OP_INIT;
    pal_wr = 1'b0;
    pal_rd = 1'b0;
    case (action)
      ACT_PAL: begin
        pal_wr = accept;
      end
      ACT_START: begin
        has_res = 1'b1;
        op_next = init_done ? OP_START : OP_REFUSED;
      end
      ACT_PIXEL: begin
        has_res = draw_enable;
        op_next = OP_PIXEL;
        pal_rd = accept && draw_enable;
      end
      ACT_END: begin
        has_res = 1'b1;
        op_next = (discard || skip_count != 2'd3) ? OP_END_ABORT : OP_END_OK;
      end
      ACT_INIT: begin
        has_res = 1'b1;
        op_next = OP_INIT;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_done <= 1'b0;
      skip_count <= 2'd0;
      draw_enable <= 1'b0;
    end else if (accept) begin
      case (action)
        ACT_START: begin
          if (!init_done) begin
            init_done <= 1'b1;
            skip_count <= 2'd0;
          end else begin
            draw_enable <= skip_count == 2'd3;
          end
        end
        ACT_END: begin
          skip_count <= skip_count + 2'd1;
        end
        ACT_INIT: begin
          init_done <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && has_res) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      s1_op <= op_next;
      s1_pix <= pixel_value;
    end
  end

  ppfs_palette #(
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (pal_wr),
    .wr_addr (pal_index),
    .wr_data ({pal_red, pal_green, pal_blue}),
    .rd_en   (pal_rd),
    .rd_addr (pixel_value[7:0]),
    .rd_data (pal_rgb)
  );

  ppfs_result_build u_build (
    .op      (s1_op),
    .pix     (s1_pix),
    .pal_rgb (pal_rgb),
    .cfg     (cfg),
    .res     (res),
    .cnt     (cnt)
  );

  ppfs_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .ld_cnt    (cnt),
    .ld_res    (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind = out_res.kind;
  assign data = out_res.data;
  assign last = out_res.last;

endmodule

`default_nettype wire

/* rtl/ppfs_palette.sv */
// palette memory: one write port, one registered read port, per-entry valid bits
// uses ppfs_pkg; entries never written read back as zero color
`default_nettype none

module ppfs_palette #(
  parameter int DEPTH = ppfs_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [7:0]  wr_addr,
  input  wire logic [23:0] wr_data,
  input  wire logic        rd_en,
  input  wire logic [7:0]  rd_addr,
  output logic      [23:0] rd_data
);
  import ppfs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [23:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [23:0] rd_q;
  logic rd_hit;
  logic wr_in_range;
  logic rd_in_range;

  assign wr_in_range = {1'b0, wr_addr} < 9'(DEPTH);
  assign rd_in_range = {1'b0, rd_addr} < 9'(DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en && wr_in_range) begin
        valid[wr_addr[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= rd_in_range && valid[rd_addr[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_hit ? rd_q : 24'd0;

endmodule

`default_nettype wire

/* rtl/ppfs_result_build.sv */
// builds the result list of one request from its decoded op, pixel and palette color
// uses ppfs_pkg for op codes, result records and channel expansion
`default_nettype none

module ppfs_result_build (
  input  wire ppfs_pkg::op_t                     op,
  input  wire logic [31:0]                       pix,
  input  wire logic [23:0]                       pal_rgb,
  input  wire ppfs_pkg::cfg_t                    cfg,
  output ppfs_pkg::result_t [ppfs_pkg::NUM_RES-1:0] res,
  output logic [ppfs_pkg::CNT_W-1:0]             cnt
);
  import ppfs_pkg::*;

  logic [7:0] b;
  logic [7:0] g;
  logic [7:0] r;

  always_comb begin
    case (cfg.pixel_format)
      FMT_PAL8: begin
        r = pal_rgb[23:16];
        g = pal_rgb[15:8];
        b = pal_rgb[7:0];
      end
      FMT_RGB555: begin
        b = expand5(pix[4:0]);
        g = expand5(pix[9:5]);
        r = expand5(pix[14:10]);
      end
      FMT_RGB565: begin
        b = expand5(pix[4:0]);
        g = expand6(pix[10:5]);
        r = expand5(pix[15:11]);
      end
      default: begin
        b = pix[7:0];
        g = pix[15:8];
        r = pix[23:16];
      end
    endcase
  end

  always_comb begin
    res = '0;
    cnt = CNT_W'(1);
    case (op)
      OP_REFUSED: begin
        res[0] = '{kind: KIND_REFUSED, data: 32'd0, last: 1'b1};
      end
      OP_START: begin
        cnt = CNT_W'(2);
        res[0] = '{kind: KIND_DWORD, data: cfg.new_sig, last: 1'b0};
        res[1] = '{kind: KIND_DWORD, data: {cfg.frame_width, cfg.frame_height}, last: 1'b1};
      end
      OP_PIXEL: begin
        cnt = CNT_W'(3);
        res[0] = '{kind: KIND_BYTE, data: {24'd0, b}, last: 1'b0};
        res[1] = '{kind: KIND_BYTE, data: {24'd0, g}, last: 1'b0};
        res[2] = '{kind: KIND_BYTE, data: {24'd0, r}, last: 1'b1};
      end
      OP_END_ABORT: begin
        res[0] = '{kind: KIND_DWORD, data: cfg.abort_sig, last: 1'b1};
      end
      OP_END_OK: begin
        res[0] = '{kind: KIND_BYTE, data: {24'd0, END_OK_BYTE}, last: 1'b1};
      end
      OP_INIT: begin
        res[0] = '{kind: KIND_DWORD, data: cfg.init_sig, last: 1'b1};
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ppfs_emitter.sv */
// output register bank: holds one request's results, sends one per out_ready cycle
// uses ppfs_pkg result records; reloads on the cycle its last result is taken
`default_nettype none

module ppfs_emitter (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  load,
  input  wire logic [ppfs_pkg::CNT_W-1:0]            ld_cnt,
  input  wire ppfs_pkg::result_t [ppfs_pkg::NUM_RES-1:0] ld_res,
  output logic                                       load_ok,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output ppfs_pkg::result_t                          out_res
);
  import ppfs_pkg::*;

  result_t [NUM_RES-1:0] slot;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] pos;

  assign out_valid = rem != '0;
  assign load_ok = (rem == '0) || (rem == CNT_W'(1) && out_ready);
  assign out_res = slot[pos];

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= ld_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      pos <= '0;
    end else if (load) begin
      rem <= ld_cnt;
      pos <= '0;
    end else if (out_valid && out_ready) begin
      rem <= rem - CNT_W'(1);
      pos <= pos + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* rtl/ppfs_checker.sv */
// port-level checks on the result channel of the palette pixel frame streamer
// uses ppfs_pkg kind codes; attached to the top level by the bind below
`default_nettype none

module ppfs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [31:0] data,
  input wire logic        last
);
  import ppfs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data) && $stable(last))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // results of one request leave without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("gap inside a request's results");

  a_refused_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_REFUSED |-> last && data == 32'd0)
    else $error("bad refused result");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_BYTE || kind == KIND_DWORD || kind == KIND_REFUSED)
    else $error("unknown result kind");

endmodule

bind palette_pixel_frame_streamer ppfs_checker u_ppfs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .data      (data),
  .last      (last)
);

`default_nettype wire
